// ----- sv/abfab_pkg.sv -----
// Package: shared types, constants and codes for the A/B feed arbiter book updater.
package abfab_pkg;

  localparam int unsigned LEVEL_INDEX_BITS = 10;
  localparam int unsigned STORE_ADDR_W     = LEVEL_INDEX_BITS + 1;
  localparam int unsigned STORE_DEPTH      = 2 ** STORE_ADDR_W;
  localparam int unsigned LEVEL_ADDR_W     = 11;
  localparam int unsigned SCALE_SHIFT      = 16;
  localparam int unsigned CFG_IDX_W        = 1;
  localparam int unsigned CFG_DATA_W       = 16;

  localparam logic [7:0]  BID_SIDE         = 8'h42;
  localparam logic [31:0] SEQ_RESET        = 32'd1;
  localparam logic [31:0] ASK_RESET        = 32'hFFFF_FFFF;

  localparam logic [CFG_IDX_W-1:0] REG_PRICE_SCALE  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_LEVEL_OFFSET = 1'b1;

  typedef struct packed {
    logic        a_valid;
    logic [31:0] a_seq;
    logic [7:0]  a_side;
    logic [31:0] a_qty;
    logic [31:0] a_price;
    logic        b_valid;
    logic [31:0] b_seq;
    logic [7:0]  b_side;
    logic [31:0] b_qty;
    logic [31:0] b_price;
  } in_item_t;

  typedef struct packed {
    logic                    admitted;
    logic                    admitted_feed;
    logic                    b_consumed;
    logic [31:0]             best_bid;
    logic [31:0]             bid_qty;
    logic [31:0]             best_ask;
    logic [31:0]             ask_qty;
    logic [LEVEL_ADDR_W-1:0] level_addr;
    logic [31:0]             level_total;
  } out_item_t;

  typedef struct packed {
    logic [31:0] best_bid;
    logic [31:0] bid_qty;
    logic [31:0] best_ask;
    logic [31:0] ask_qty;
  } book_t;

  typedef struct packed {
    logic                    rd_en;
    logic [STORE_ADDR_W-1:0] rd_addr;
    logic                    wr_en;
    logic [STORE_ADDR_W-1:0] wr_addr;
    logic [31:0]             wr_data;
  } store_req_t;

endpackage

// ----- sv/abfab_if.sv -----
// Interfaces: valid/ready channels for input items and result items.
interface abfab_in_if;
  logic                  valid;
  logic                  ready;
  abfab_pkg::in_item_t   data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface abfab_out_if;
  logic                  valid;
  logic                  ready;
  abfab_pkg::out_item_t  data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ----- sv/ab_feed_arbiter_book_updater_core.sv -----
// Top level: A/B feed arbiter with best bid/ask tracking and per-level quantity accumulation.
// Usage:
//   in_i   carries one item per transfer: one optional add message from each feed.
//          Feed A is tried first against the expected sequence number; B only if A
//          did not match. A message from B that is tried is consumed either way.
//   out_o  returns exactly one result per item: admission flags, the best bid/ask
//          after the item, and the level address and running total it updated.
//   cfg_*  writes price_scale (index 0) or level_offset (index 1); only while idle.
// Timing:
//   One item per cycle sustained while out_o accepts and no clearing pass runs. Results
//   pass stage 1, stage 2 and the output register: multiply into stage 1, level address
//   and store read, then accumulate and write back. The read-modify-write on the level
//   store has a bypass of the write in flight, so equal consecutive addresses are fine.
// Reset:
//   Sequence expects 1, bid is 0, ask is all ones. A clearing pass then zeroes all
//   2^(LEVEL_INDEX_BITS+1) = 2048 level store entries, with in_i.ready low.
// Stall:
//   When out_o is held off with a result waiting, the whole pipe holds and
//   in_i.ready drops; a transfer on out_o frees a slot in the same cycle.
module ab_feed_arbiter_book_updater_core (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  abfab_in_if.sink                           in_i,
  abfab_out_if.source                        out_o,
  input  logic                               cfg_we_i,
  input  logic [abfab_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  logic [abfab_pkg::CFG_DATA_W-1:0]   cfg_wdata_i
);

  localparam int unsigned AW = abfab_pkg::STORE_ADDR_W;
  localparam int unsigned IW = abfab_pkg::LEVEL_INDEX_BITS;

  logic [15:0] price_scale_q, level_offset_q;
  logic [31:0] exp_seq_q;
  abfab_pkg::book_t book_q, book_d;

  logic        adv, accept, busy;
  logic        a_hit, b_try, b_hit, adm;
  logic [7:0]  sel_side;
  logic [31:0] sel_qty, sel_price;
  logic        sel_bid;
  logic [47:0] product;

  logic              s1_valid_q, s1_adm_q, s1_feed_q, s1_bcons_q, s1_bid_q;
  logic [31:0]       s1_qty_q;
  logic [15:0]       s1_scaled_q;
  abfab_pkg::book_t  s1_book_q;
  logic [15:0]       s1_idx;
  logic [AW-1:0]     s1_addr;

  logic              s2_valid_q, s2_adm_q, s2_feed_q, s2_bcons_q;
  logic [31:0]       s2_qty_q;
  logic [AW-1:0]     s2_addr_q;
  abfab_pkg::book_t  s2_book_q;
  logic [31:0]       s2_total, rd_data;

  logic                  out_valid_q;
  abfab_pkg::out_item_t  out_data_q;
  abfab_pkg::store_req_t req;

  assign adv         = ~out_valid_q | out_o.ready;
  assign in_i.ready  = adv & ~busy;
  assign accept      = in_i.valid & in_i.ready;
  assign out_o.valid = out_valid_q;
  assign out_o.data  = out_data_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      price_scale_q  <= '0;
      level_offset_q <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        abfab_pkg::REG_PRICE_SCALE:  price_scale_q  <= cfg_wdata_i;
        abfab_pkg::REG_LEVEL_OFFSET: level_offset_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  always_comb begin
    a_hit     = in_i.data.a_valid && (in_i.data.a_seq == exp_seq_q);
    b_try     = ~a_hit & in_i.data.b_valid;
    b_hit     = b_try && (in_i.data.b_seq == exp_seq_q);
    adm       = a_hit | b_hit;
    sel_side  = a_hit ? in_i.data.a_side  : in_i.data.b_side;
    sel_qty   = a_hit ? in_i.data.a_qty   : in_i.data.b_qty;
    sel_price = a_hit ? in_i.data.a_price : in_i.data.b_price;
    sel_bid   = (sel_side == abfab_pkg::BID_SIDE);
    book_d    = book_q;
    if (adm && sel_bid && (sel_price > book_q.best_bid)) begin
      book_d.best_bid = sel_price;
      book_d.bid_qty  = sel_qty;
    end
    if (adm && !sel_bid && (sel_price < book_q.best_ask)) begin
      book_d.best_ask = sel_price;
      book_d.ask_qty  = sel_qty;
    end
  end

  assign product = sel_price * price_scale_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      exp_seq_q         <= abfab_pkg::SEQ_RESET;
      book_q.best_bid   <= '0;
      book_q.bid_qty    <= '0;
      book_q.best_ask   <= abfab_pkg::ASK_RESET;
      book_q.ask_qty    <= '0;
    end else if (accept) begin
      if (adm) begin
        exp_seq_q <= exp_seq_q + 32'd1;
      end
      book_q <= book_d;
    end
  end

  // stage 1: scaled price registered
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (adv) begin
      s1_valid_q <= accept;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s1_adm_q    <= adm;
      s1_feed_q   <= b_hit;
      s1_bcons_q  <= b_try;
      s1_bid_q    <= sel_bid;
      s1_qty_q    <= sel_qty;
      s1_scaled_q <= product[abfab_pkg::SCALE_SHIFT +: 16];
      s1_book_q   <= book_d;
    end
  end

  assign s1_idx  = s1_scaled_q - level_offset_q;
  assign s1_addr = {~s1_bid_q, s1_idx[IW-1:0]};

  // stage 2: store read in flight
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_valid_q <= 1'b0;
    end else if (adv) begin
      s2_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s2_adm_q   <= s1_adm_q;
      s2_feed_q  <= s1_feed_q;
      s2_bcons_q <= s1_bcons_q;
      s2_qty_q   <= s1_qty_q;
      s2_addr_q  <= s1_addr;
      s2_book_q  <= s1_book_q;
    end
  end

  assign s2_total = rd_data + s2_qty_q;

  always_comb begin
    req.rd_en   = adv;
    req.rd_addr = s1_addr;
    req.wr_en   = adv & s2_valid_q & s2_adm_q;
    req.wr_addr = s2_addr_q;
    req.wr_data = s2_total;
  end

  abfab_level_store u_store (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .req_i     (req),
    .rd_data_o (rd_data),
    .busy_o    (busy)
  );

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (adv) begin
      out_valid_q <= s2_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      out_data_q.admitted      <= s2_adm_q;
      out_data_q.admitted_feed <= s2_feed_q;
      out_data_q.b_consumed    <= s2_bcons_q;
      out_data_q.best_bid      <= s2_book_q.best_bid;
      out_data_q.bid_qty       <= s2_book_q.bid_qty;
      out_data_q.best_ask      <= s2_book_q.best_ask;
      out_data_q.ask_qty       <= s2_book_q.ask_qty;
      out_data_q.level_addr    <= s2_adm_q ? abfab_pkg::LEVEL_ADDR_W'(s2_addr_q) : '0;
      out_data_q.level_total   <= s2_adm_q ? s2_total : '0;
    end
  end

endmodule

// ----- sv/abfab_level_store.sv -----
// Level quantity store: synchronous memory with clearing pass and write-to-read forwarding.
module abfab_level_store (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  abfab_pkg::store_req_t   req_i,
  output logic [31:0]             rd_data_o,
  output logic                    busy_o
);

  logic [31:0]                          mem [abfab_pkg::STORE_DEPTH];
  logic [abfab_pkg::STORE_ADDR_W:0]     clr_cnt_q, clr_cnt_d;
  logic [31:0]                          mem_rd_q;
  logic                                 fwd_hit_q;
  logic [31:0]                          fwd_data_q;
  logic                                 busy;

  assign busy      = ~clr_cnt_q[abfab_pkg::STORE_ADDR_W];
  assign busy_o    = busy;
  assign clr_cnt_d = clr_cnt_q + 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_cnt_q <= '0;
    end else if (busy) begin
      clr_cnt_q <= clr_cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (busy) begin
      mem[clr_cnt_q[abfab_pkg::STORE_ADDR_W-1:0]] <= '0;
    end else if (req_i.wr_en) begin
      mem[req_i.wr_addr] <= req_i.wr_data;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.rd_en) begin
      mem_rd_q <= mem[req_i.rd_addr];
    end
  end

  // bypass a write that lands on the entry being read in the same cycle
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fwd_hit_q <= 1'b0;
    end else if (req_i.rd_en) begin
      fwd_hit_q <= req_i.wr_en && (req_i.wr_addr == req_i.rd_addr);
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.rd_en) begin
      fwd_data_q <= req_i.wr_data;
    end
  end

  assign rd_data_o = fwd_hit_q ? fwd_data_q : mem_rd_q;

endmodule

// ----- sv/abfab_checker.sv -----
// Checker: port-level assertions for the A/B feed arbiter book updater, bound to the top level.
module abfab_checker (
  input logic                  clk_i,
  input logic                  rst_ni,
  input logic                  out_valid_i,
  input logic                  out_ready_i,
  input abfab_pkg::out_item_t  out_data_i
);

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_data_i))
    else $error("result dropped or changed while stalled");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_data_i.admitted |->
      !out_data_i.admitted_feed && out_data_i.level_addr == '0 &&
      out_data_i.level_total == '0)
    else $error("non-admitted result carries level data");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_data_i.admitted_feed |-> out_data_i.b_consumed)
    else $error("feed B admitted without being consumed");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_data_i.admitted && !out_data_i.admitted_feed |->
      !out_data_i.b_consumed)
    else $error("feed B consumed although feed A was admitted");

endmodule

bind ab_feed_arbiter_book_updater_core abfab_checker u_abfab_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .out_valid_i (out_o.valid),
  .out_ready_i (out_o.ready),
  .out_data_i  (out_o.data)
);
